FILE: rtl/lrkf_pkg.sv
// Shared constants and types for the longest-run-with-k-flips block.
package lrkf_pkg;

   localparam int unsigned POS_W     = 16;          // string position width
   localparam int unsigned K_W       = 10;          // max_changes width
   localparam int unsigned MAX_FLIPS = 1024;        // FIFO depth per window
   localparam int unsigned PTR_W     = $clog2(MAX_FLIPS);
   localparam int unsigned CNT_W     = PTR_W;       // count never passes k <= MAX_FLIPS-1
   localparam logic [POS_W-1:0] MAX_LEN = 16'hFFFF; // letters kept per string

   // Per-window control from the top level, for both pipeline stages.
   typedef struct packed {
      logic             s0_load;   // stage 1 registers may load this cycle
      logic             s0_step;   // accepted letter inside MAX_LEN
      logic             s0_other;  // letter is opposite of window target
      logic             s0_clear;  // accepted letter is last of string
      logic [POS_W-1:0] s0_pos;    // position of accepted letter
      logic [K_W-1:0]   k;         // allowed changes
      logic             s1_step;   // stage 1 updates the window edge
      logic             s1_clear;  // stage 1 holds the last letter
      logic [POS_W-1:0] s1_pos;    // position held in stage 1
   } win_ctl_type;

endpackage

FILE: rtl/lrkf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrkf_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lrkf_window.sv
// One sliding window: position FIFO in RAM, head/count pointers, left edge.
module lrkf_window (
   input  logic                      clock,
   input  logic                      reset,
   input  lrkf_pkg::win_ctl_type     ctl,
   output logic [lrkf_pkg::POS_W-1:0] length
);

   logic [lrkf_pkg::PTR_W-1:0] head_ff, head_in;
   logic [lrkf_pkg::CNT_W-1:0] count_ff, count_in;
   logic [lrkf_pkg::POS_W-1:0] left_ff, left_in;
   logic                       pop_ff, fwd_ff;
   logic                       push, pop;
   logic [lrkf_pkg::PTR_W-1:0] tail;
   logic [lrkf_pkg::POS_W-1:0] rd_data;
   logic [lrkf_pkg::POS_W-1:0] left_new;

   // stage 0: push at tail, pop oldest once count would pass k
   assign push = ctl.s0_step & ctl.s0_other;
   assign pop  = push & (count_ff >= ctl.k);
   assign tail = head_ff + lrkf_pkg::PTR_W'(count_ff);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.s0_clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (pop) begin
         head_in  = head_ff + 1'b1;
      end else if (push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         pop_ff   <= 1'b0;
         fwd_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (ctl.s0_load) begin
            pop_ff <= pop;
            // empty FIFO: the popped entry is the one written this cycle
            fwd_ff <= (count_ff == '0);
         end
      end
   end

   lrkf_ram #(
      .WIDTH (lrkf_pkg::POS_W),
      .DEPTH (lrkf_pkg::MAX_FLIPS)
   ) u_fifo (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail),
      .wr_data (ctl.s0_pos),
      .rd_en   (pop),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // stage 1: move left edge past the popped position
   always_comb begin
      left_new = left_ff;
      if (pop_ff) begin
         left_new = fwd_ff ? (ctl.s1_pos + 1'b1) : (rd_data + 1'b1);
      end
      left_in = left_ff;
      if (ctl.s1_clear) begin
         left_in = '0;
      end else if (ctl.s1_step) begin
         left_in = left_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   assign length = ctl.s1_pos + 1'b1 - left_new;

endmodule

FILE: rtl/longest_run_with_k_flips.sv
// Top level: longest run of one letter reachable with at most k changed letters.
// The result passes the stage 1 registers and then the output register before it appears on rsp.
// Throughput: one item per cycle while not stalled; each window does one RAM write and one RAM read.
// Only a result still waiting in the output register, with the next last item
// right behind it, holds req_tready low.
// Reset (synchronous, active high) clears pointers, positions and the result;
// the position RAMs are not cleared and need no clearing pass.
module longest_run_with_k_flips (
   input  logic        clock,
   input  logic        reset,
   // configuration: max_changes
   input  logic        csr_we,
   input  logic [9:0]  csr_wdata,
   // letter stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] letter (0 = 'a', 1 = 'b'), [7:1] zero
   input  logic        req_tlast,   // last letter of the string
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] longest
   output logic        rsp_tuser    // [0] overflow
);

   // configuration register
   logic [lrkf_pkg::K_W-1:0] k_ff;

   // stage 0: accepted letter
   logic                       accept, active, stall;
   logic [lrkf_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       too_long_ff, too_long_in;

   // stage 1: window edge update and best length
   logic                       s1_valid_ff, s1_last_ff, s1_active_ff, s1_ovf_ff;
   logic [lrkf_pkg::POS_W-1:0] s1_pos_ff;
   logic                       s1_go;
   logic [lrkf_pkg::POS_W-1:0] best_ff, best_in, best_new;
   logic [lrkf_pkg::POS_W-1:0] len_a, len_b;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lrkf_pkg::POS_W-1:0] rsp_longest_ff;
   logic                       rsp_overflow_ff;
   logic                       rsp_load;

   lrkf_pkg::win_ctl_type ctl_a, ctl_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (csr_we) begin
         k_ff <= csr_wdata;
      end
   end

   // Only a finished string whose result cannot leave holds the pipe.
   assign stall      = s1_valid_ff & s1_last_ff & rsp_valid_ff & ~rsp_tready;
   assign req_tready = ~stall;
   assign accept     = req_tvalid & req_tready;
   assign active     = (pos_ff < lrkf_pkg::MAX_LEN);

   // Letters past MAX_LEN only mark the string as too long.
   always_comb begin
      pos_in      = pos_ff;
      too_long_in = too_long_ff;
      if (accept) begin
         if (req_tlast) begin
            pos_in      = '0;
            too_long_in = 1'b0;
         end else if (active) begin
            pos_in      = pos_ff + 1'b1;
         end else begin
            too_long_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         too_long_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         too_long_ff <= too_long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_last_ff   <= req_tlast;
         s1_active_ff <= active;
         s1_pos_ff    <= pos_ff;
         s1_ovf_ff    <= too_long_ff | ~active;
      end
   end

   assign s1_go = s1_valid_ff & ~stall;

   // Window for target 'a' tracks 'b' letters, and the other way round.
   always_comb begin
      ctl_a.s0_load  = ~stall;
      ctl_a.s0_step  = accept & active;
      ctl_a.s0_other = req_tdata[0];
      ctl_a.s0_clear = accept & req_tlast;
      ctl_a.s0_pos   = pos_ff;
      ctl_a.k        = k_ff;
      ctl_a.s1_step  = s1_go & s1_active_ff;
      ctl_a.s1_clear = s1_go & s1_last_ff;
      ctl_a.s1_pos   = s1_pos_ff;
      ctl_b          = ctl_a;
      ctl_b.s0_other = ~req_tdata[0];
   end

   lrkf_window u_win_a (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_a),
      .length (len_a)
   );

   lrkf_window u_win_b (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_b),
      .length (len_b)
   );

   // best of both windows, reset after each string's result
   always_comb begin
      best_new = best_ff;
      if (s1_active_ff) begin
         if (len_a > best_new) begin
            best_new = len_a;
         end
         if (len_b > best_new) begin
            best_new = len_b;
         end
      end
      best_in = best_ff;
      if (s1_go) begin
         best_in = s1_last_ff ? '0 : best_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

   // output register: loads on the last letter, drains on rsp handshake
   assign rsp_load = s1_go & s1_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_longest_ff  <= best_new;
         rsp_overflow_ff <= s1_ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_longest_ff;
   assign rsp_tuser  = rsp_overflow_ff;

endmodule

FILE: rtl/lrkf_checker.sv
// Port-level checks for the longest-run-with-k-flips block, with bind.
module lrkf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // every string holds at least one letter, so a run of one is always reachable
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != 16'd0)
      else $error("zero length result");

   // a fresh result must follow an accepted last item
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without a last item two cycles before");

endmodule

bind longest_run_with_k_flips lrkf_checker u_lrkf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: dv/tb_longest_run_with_k_flips.sv
// Self-checking testbench for longest_run_with_k_flips: stream driver, predictor, monitor.
module tb_longest_run_with_k_flips;

   // one letter on the input stream
   typedef struct {
      bit letter;   // 0 = 'a', 1 = 'b'
      bit last;
   } run_letter_type;

   // one result on the output stream
   typedef struct {
      logic [15:0] longest;
      logic        overflow;
   } run_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [9:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;     // [0] letter, [7:1] zero
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [15:0] longest
   logic        rsp_tuser;          // [0] overflow

   // stimulus and expectations
   run_letter_type letters_pending[$];
   run_result_type results_due[$];
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          mismatch_count = 0;

   // predictor state: one window per target letter
   logic [lrkf_pkg::K_W-1:0] k_setting = '0;
   int unsigned    str_pos = 0;      // letters taken in this string
   int unsigned    best_run = 0;
   bit             over_len = 1'b0;
   int unsigned    a_left = 0;       // left edge of the all-'a' window
   int unsigned    b_left = 0;       // left edge of the all-'b' window
   int unsigned    a_others[$];      // 'b' positions inside the 'a' window
   int unsigned    b_others[$];      // 'a' positions inside the 'b' window

   longest_run_with_k_flips u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Advance both windows by one accepted letter; on last, queue the result
   // and clear per-string state. Letters past MAX_LEN only flag overflow.
   function automatic void note_letter(input bit letter, input bit last);
      int unsigned run_a;
      int unsigned run_b;
      if (str_pos < lrkf_pkg::MAX_LEN) begin
         if (letter) begin
            a_others = {a_others, str_pos};
            if (a_others.size() > k_setting) a_left = a_others.pop_front() + 1;
         end else begin
            b_others = {b_others, str_pos};
            if (b_others.size() > k_setting) b_left = b_others.pop_front() + 1;
         end
         run_a = str_pos + 1 - a_left;
         run_b = str_pos + 1 - b_left;
         if (run_a > best_run) best_run = run_a;
         if (run_b > best_run) best_run = run_b;
         str_pos++;
      end else begin
         over_len = 1'b1;
      end
      if (last) begin
         results_due = {results_due,
                        run_result_type'{longest: (best_run > 65535) ? 16'hFFFF
                                                                     : best_run[15:0],
                                         overflow: over_len}};
         str_pos  = 0;
         best_run = 0;
         over_len = 1'b0;
         a_left   = 0;
         b_left   = 0;
         a_others.delete();
         b_others.delete();
      end
   endfunction

   // Driver: a new item may go out once the current one is taken (or none is up).
   always @(posedge clock) begin : letter_driver
      run_letter_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) note_letter(req_tdata[0], req_tlast);
         if (letters_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = letters_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {7'b0, nxt.letter};
            req_tlast  <= nxt.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: compare each taken result with the oldest expectation.
   always @(posedge clock) begin : result_monitor
      run_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result longest=%0d overflow=%b",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata !== want.longest)
                  report_mismatch($sformatf("longest got %0d want %0d",
                                            rsp_tdata, want.longest));
               if (rsp_tuser !== want.overflow)
                  report_mismatch($sformatf("overflow got %b want %b",
                                            rsp_tuser, want.overflow));
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Sampled on the falling edge so queue sizes are settled.
   task automatic wait_drained();
      @(negedge clock);
      while (letters_pending.size() != 0 || req_tvalid || results_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_max_changes(input logic [lrkf_pkg::K_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      k_setting  = value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // 'a'/'b' characters, last marker on the final one
   task automatic queue_word(input string word);
      for (int i = 0; i < word.len(); i++)
         letters_pending = {letters_pending,
                            run_letter_type'{letter: (word[i] == "b"),
                                             last: (i == word.len() - 1)}};
   endtask

   task automatic queue_string(input int len, input int b_pct);
      for (int i = 0; i < len; i++)
         letters_pending = {letters_pending,
                            run_letter_type'{letter: ($urandom_range(99) < b_pct),
                                             last: (i == len - 1)}};
   endtask

   // Mostly short strings, a share of single letters (back-to-back lasts)
   // and some long ones; letter bias varies per string.
   task automatic queue_random_string(inout int queued);
      int len;
      int pick;
      int b_pct;
      pick = $urandom_range(99);
      if (pick < 20) len = 1;
      else if (pick < 80) len = $urandom_range(16, 2);
      else len = $urandom_range(120, 17);
      pick = $urandom_range(3);
      if (pick == 0) b_pct = 50;
      else if (pick == 1) b_pct = $urandom_range(15);
      else if (pick == 2) b_pct = $urandom_range(100, 85);
      else b_pct = $urandom_range(100);
      queue_string(len, b_pct);
      queued += len;
   endtask

   initial begin : stimulus
      int  k_list[8];
      int  queued;
      bit  paused;
      k_list = '{0, 1023, 1, 2, -1, 5, -1, 3};   // -1: random k
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: single letters, plain runs, k at both extremes
      write_max_changes(10'd0);
      @(negedge clock);
      queue_word("a");
      queue_word("b");
      queue_word("aabbba");
      wait_drained();
      repeat (4) @(posedge clock);
      write_max_changes(10'd1);
      @(negedge clock);
      queue_word("abaab");
      queue_word("bba");
      wait_drained();
      repeat (4) @(posedge clock);
      write_max_changes(10'd1023);
      @(negedge clock);
      queue_word("babab");

      // random phases: idling none / sender / receiver / both
      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         write_max_changes((k_list[ph] < 0) ? 10'($urandom_range(1023)) : 10'(k_list[ph]));
         case (ph % 4)
            0: set_idling(0, 0);
            1: set_idling(56, 0);
            2: set_idling(0, 56);
            default: set_idling(8, 8);
         endcase
         queued = 0;
         paused = 1'b0;
         while (queued < 150) begin
            // in phase 1 the sender holds off mid-phase until all results are back
            if (ph == 1 && queued >= 80 && !paused) begin
               wait_drained();
               paused = 1'b1;
            end
            queue_random_string(queued);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // about 1300 letters finish well inside this limit even with heavy stalls
   initial begin : watchdog
      #200000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
